[rtl/sbat_pkg.sv]
// Shared types, codes and the sort-order compare of the sprite sort-and-batch core.
// No dependencies; the key store, cell and core files import this package.
package sbat_pkg;

    localparam int MAX_SPRITES_DEF = 64;
    localparam int SLOT_W          = 6;
    localparam int OFFSET_W        = 9;
    localparam int RUN_LEN_W       = 7;
    localparam int TRI_W           = 8;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 2;
    localparam logic [OFFSET_W-1:0] IDX_PER_SPRITE = 9'd6;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_ORDER   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_FIRST = 1'd1;

    localparam logic [1:0] DORD_NONE = 2'd0;

    typedef struct packed {
        logic              operation;
        logic [7:0]        priority_req;
        logic signed [31:0] depth;
        logic [15:0]       texture_id;
    } t_in_word;

    typedef struct packed {
        logic [SLOT_W-1:0]   slot_index;
        logic [15:0]         texture_out;
        logic                run_first;
        logic [OFFSET_W-1:0] run_start_offset;
        logic                run_last;
        logic [TRI_W-1:0]    run_triangles;
        logic                last;
    } t_out_word;

    typedef struct packed {
        logic [7:0]         prio;
        logic signed [31:0] depth;
        logic [15:0]        tex;
    } t_key;

    typedef struct packed {
        logic              valid;
        t_key              key;
        logic [SLOT_W-1:0] slot;
    } t_cell;

    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctrl;

    typedef struct packed {
        logic [1:0] depth_order;
        logic       texture_first;
    } t_sort_cfg;

    // true when a must come strictly before b
    function automatic logic key_before(t_key a, t_key b, t_sort_cfg cfg);
        logic dless;
        logic res;
        dless = cfg.depth_order[0] ? ($signed(a.depth) > $signed(b.depth))
                                   : ($signed(a.depth) < $signed(b.depth));
        if (cfg.depth_order == DORD_NONE) begin
            res = 1'b0;
        end else if (a.prio != b.prio) begin
            res = a.prio < b.prio;
        end else if (cfg.texture_first) begin
            res = (a.tex != b.tex) ? (a.tex < b.tex) : dless;
        end else begin
            res = (a.depth != b.depth) ? dless : (a.tex < b.tex);
        end
        return res;
    endfunction

endpackage

[rtl/sbat_if.sv]
// Valid/ready channel carrying one word of a chosen payload type.
// No dependencies; payload types come from sbat_pkg at the instance.
interface sbat_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/sbat_key_store.sv]
// Load-order key memory: one write port, one registered read port.
// Depends on sbat_pkg for the key type.
module sbat_key_store #(
    parameter int DEPTH = sbat_pkg::MAX_SPRITES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  sbat_pkg::t_key           i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output sbat_pkg::t_key           o_rdata
);
    import sbat_pkg::*;

    t_key r_mem [DEPTH];
    t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/sbat_cell.sv]
// One cell of the insertion chain: holds one sorted entry, inserts or shifts.
// Depends on sbat_pkg for entry types and the key compare.
module sbat_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbat_pkg::t_cell_ctrl i_ctrl,
    input  sbat_pkg::t_sort_cfg i_cfg,
    input  sbat_pkg::t_cell     i_new,
    input  sbat_pkg::t_cell     i_prev,
    input  logic                i_prev_ins,
    input  sbat_pkg::t_cell     i_next,
    output sbat_pkg::t_cell     o_cell,
    output logic                o_ins
);
    import sbat_pkg::*;

    t_cell r_cell;
    t_cell n_cell;
    logic  w_ins;

    assign w_ins = !r_cell.valid || key_before(i_new.key, r_cell.key, i_cfg);

    always_comb begin
        n_cell = r_cell;
        if (i_ctrl.shift) begin
            n_cell = i_next;
        end else if (i_ctrl.insert && w_ins) begin
            n_cell = i_prev_ins ? i_prev : i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.key  <= n_cell.key;
        r_cell.slot <= n_cell.slot;
    end

    assign o_cell = r_cell;
    assign o_ins  = w_ins;
endmodule

[rtl/sprite_sort_and_batch_core.sv]
// Sprite sort-and-batch core: load keys, stable-sort on flush, emit texture runs.
// Depends on sbat_pkg, sbat_if, sbat_key_store and sbat_cell.
//
// i_in carries load and flush words; o_out carries one sorted sprite per word.
// Configuration (depth order, texture first) is written through i_cfg_we,
// i_cfg_index and i_cfg_data; the user must write it only while the core is
// idle, and the core itself does not enforce this. A load is accepted every
// cycle while idle; it writes the next slot of the key memory, and loads past
// MAX_SPRITES are dropped. A flush of n stored sprites reads the key memory
// one slot per cycle and inserts each key into the cell chain. The chain
// then shifts out one sorted sprite per cycle while the receiver does not
// stall. The sort is paced by the single memory read port and the
// one-entry-per-cycle chain. A flush with nothing stored gives no word and
// leaves the core idle. i_in is not ready during a flush.
// When o_out stalls the chain holds and the current word stays on the port.
// Reset clears the sprite count, the chain and the configuration; the key
// memory needs no clearing since only loaded slots are read.
module sprite_sort_and_batch_core #(
    parameter int MAX_SPRITES = sbat_pkg::MAX_SPRITES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sbat_if.sink                             i_in,
    sbat_if.source                           o_out,
    input  logic                             i_cfg_we,
    input  logic [sbat_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sbat_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sbat_pkg::*;

    localparam int AW = $clog2(MAX_SPRITES);
    localparam int CW = $clog2(MAX_SPRITES + 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SPRITES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SORT = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          r_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_rd_ptr;
    logic                r_rd_vld;
    logic [AW-1:0]       r_rd_slot;
    t_sort_cfg           r_cfg;
    logic [OFFSET_W-1:0] r_pos6;
    logic                r_at_start;
    logic [15:0]         r_prev_tex;
    logic [OFFSET_W-1:0] r_run_off;
    logic [RUN_LEN_W-1:0] r_run_len;

    logic    w_in_fire;
    logic    w_out_fire;
    logic    w_load;
    logic    w_rd_en;
    t_key    w_wkey;
    t_key    w_rkey;
    t_cell   w_new;
    t_cell_ctrl w_ctrl;
    t_cell   w_cells [MAX_SPRITES];
    logic    w_ins   [MAX_SPRITES];
    logic [MAX_SPRITES-1:0] w_valid;
    t_cell   w_head;
    t_cell   w_second;
    logic    w_first;
    logic    w_run_last;
    logic [RUN_LEN_W-1:0] w_run_len;
    logic [OFFSET_W-1:0]  w_run_off;

    // input side
    assign i_in.ready = (r_state == ST_IDLE);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_load     = w_in_fire && (i_in.data.operation == OP_LOAD) && (r_count < COUNT_MAX);

    assign w_wkey.prio  = i_in.data.priority_req;
    assign w_wkey.depth = i_in.data.depth;
    assign w_wkey.tex   = i_in.data.texture_id;

    assign w_rd_en = (r_state == ST_SORT) && (r_rd_ptr < r_count);

    sbat_key_store #(.DEPTH(MAX_SPRITES)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_wkey),
        .i_re    (w_rd_en),
        .i_raddr (r_rd_ptr[AW-1:0]),
        .o_rdata (w_rkey)
    );

    // cell chain
    assign w_new.valid = 1'b1;
    assign w_new.key   = w_rkey;
    assign w_new.slot  = SLOT_W'(r_rd_slot);

    assign w_ctrl.insert = r_rd_vld;
    assign w_ctrl.shift  = w_out_fire;

    genvar k;
    generate
        for (k = 0; k < MAX_SPRITES; k++) begin : g_cell
            t_cell w_prev;
            t_cell w_next;
            logic  w_prev_ins;
            if (k == 0) begin : g_head
                assign w_prev     = '0;
                assign w_prev_ins = 1'b0;
            end else begin : g_body
                assign w_prev     = w_cells[k-1];
                assign w_prev_ins = w_ins[k-1];
            end
            if (k == MAX_SPRITES - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_link
                assign w_next = w_cells[k+1];
            end
            sbat_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctrl     (w_ctrl),
                .i_cfg      (r_cfg),
                .i_new      (w_new),
                .i_prev     (w_prev),
                .i_prev_ins (w_prev_ins),
                .i_next     (w_next),
                .o_cell     (w_cells[k]),
                .o_ins      (w_ins[k])
            );
            assign w_valid[k] = w_cells[k].valid;
        end
    endgenerate

    // output side
    assign w_head     = w_cells[0];
    assign w_second   = w_cells[1];
    assign w_first    = r_at_start || (r_prev_tex != w_head.key.tex);
    assign w_run_last = !w_second.valid || (w_second.key.tex != w_head.key.tex);
    assign w_run_len  = w_first ? RUN_LEN_W'(1) : (r_run_len + RUN_LEN_W'(1));
    assign w_run_off  = w_first ? r_pos6 : r_run_off;

    assign o_out.valid                 = (r_state == ST_EMIT) && w_head.valid;
    assign o_out.data.slot_index       = w_head.slot;
    assign o_out.data.texture_out      = w_head.key.tex;
    assign o_out.data.run_first        = w_first;
    assign o_out.data.run_start_offset = w_run_off;
    assign o_out.data.run_last         = w_run_last;
    assign o_out.data.run_triangles    = w_run_last ? {w_run_len, 1'b0} : '0;
    assign o_out.data.last             = !w_second.valid;

    assign w_out_fire = o_out.valid && o_out.ready;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_rd_ptr <= '0;
            r_rd_vld <= 1'b0;
            r_cfg    <= '0;
        end else begin
            r_rd_vld <= w_rd_en;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEPTH_ORDER:   r_cfg.depth_order   <= i_cfg_data;
                    CFG_TEXTURE_FIRST: r_cfg.texture_first <= i_cfg_data[0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    r_rd_ptr <= '0;
                    if (w_load) begin
                        r_count <= r_count + CW'(1);
                    end else if (w_in_fire && (i_in.data.operation == OP_FLUSH)
                                 && (r_count != '0)) begin
                        r_state <= ST_SORT;
                    end
                end
                ST_SORT: begin
                    if (w_rd_en) begin
                        r_rd_ptr <= r_rd_ptr + CW'(1);
                    end else if (!r_rd_vld) begin
                        r_state <= ST_EMIT;
                        r_count <= '0;
                    end
                end
                ST_EMIT: begin
                    if (w_out_fire && !w_second.valid) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= r_rd_ptr[AW-1:0];
        if (r_state != ST_EMIT) begin
            r_pos6     <= '0;
            r_at_start <= 1'b1;
        end else if (w_out_fire) begin
            r_pos6     <= r_pos6 + IDX_PER_SPRITE;
            r_at_start <= 1'b0;
            r_prev_tex <= w_head.key.tex;
            r_run_off  <= w_run_off;
            r_run_len  <= w_run_len;
        end
    end

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX)
        else $error("sprite count beyond capacity");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + MAX_SPRITES'(1)) & w_valid) == '0)
        else $error("cell chain has a gap");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (w_valid == '0))
        else $error("input ready with entries left in chain");

    a_flush_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_in.data.operation == OP_FLUSH) && (r_count != '0))
        |=> (r_state == ST_SORT))
        else $error("flush did not start sorting");

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && o_out.data.last) |=> (w_valid == '0) && (r_state == ST_IDLE))
        else $error("chain not empty after final word");

endmodule
